// ===== hw/rtl/transitive_closure_engine_macros.svh =====
// Assertion macros for the transitive closure engine.
// Every macro samples on the rising edge of clock and is disabled during reset.
`ifndef TRANSITIVE_CLOSURE_ENGINE_MACROS_SVH
`define TRANSITIVE_CLOSURE_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// The property holds at every clock edge.
`define TCE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define TCE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TCE_ASSERT(label, prop, msg)
`define TCE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/tce_pkg.sv =====
`timescale 1ns / 1ps
package tce_pkg;

   // Fixed field widths.
   localparam int ROW_W   = 32;
   localparam int BIT_W   = 5;
   localparam int COUNT_W = 6;

   // Block phases.
   typedef enum logic [1:0] {
      PH_LOAD,
      PH_PREP,
      PH_CLOSE,
      PH_EMIT
   } phase_type;

   // Operation applied to every lane in the same cycle.
   typedef enum logic [1:0] {
      LOP_HOLD,
      LOP_LOAD,
      LOP_PREP,
      LOP_PIVOT
   } lane_op_type;

   // Control shared by all lanes.
   typedef struct packed {
      lane_op_type        op;
      logic [BIT_W-1:0]   load_sel;
      logic [BIT_W-1:0]   bit_sel;
      logic [COUNT_W-1:0] fill_count;
      logic [ROW_W-1:0]   col_mask;
      logic [ROW_W-1:0]   load_row;
      logic [ROW_W-1:0]   pivot_row;
   } lane_ctrl_type;

endpackage

// ===== hw/rtl/tce_if.sv =====
`timescale 1ns / 1ps
// Input channel: one adjacency row per transaction.
interface tce_req_if;
   import tce_pkg::*;
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] adjacency_row;
   logic             last_row;

   modport source (output valid, output adjacency_row, output last_row, input ready);
   modport sink (input valid, input adjacency_row, input last_row, output ready);
endinterface

// Result channel: one closed row per transaction.
interface tce_rsp_if;
   import tce_pkg::*;
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] closed_row;
   logic [BIT_W-1:0] row_number;
   logic             last_out;

   modport source (output valid, output closed_row, output row_number, output last_out,
                   input ready);
   modport sink (input valid, input closed_row, input row_number, input last_out,
                 output ready);
endinterface

// ===== hw/rtl/tce_lane.sv =====
`timescale 1ns / 1ps
module tce_lane import tce_pkg::*; #(
   parameter int LANE_IDX = 0
) (
   input  logic             clock,
   input  lane_ctrl_type    ctrl,
   output logic [ROW_W-1:0] row
);

   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;

   // Row update for the operation of this cycle.
   always_comb begin
      row_in = row_ff;
      unique case (ctrl.op)
         LOP_HOLD: row_in = row_ff;
         LOP_LOAD: begin
            if (ctrl.load_sel == BIT_W'(LANE_IDX)) begin
               row_in = ctrl.load_row;
            end
         end
         // Rows beyond the fill count were never written in this run and read as zero.
         LOP_PREP: begin
            if (COUNT_W'(LANE_IDX) < ctrl.fill_count) begin
               row_in = row_ff & ctrl.col_mask;
            end else begin
               row_in = '0;
            end
         end
         // A row that reaches the pivot takes over everything the pivot reaches.
         LOP_PIVOT: begin
            if (row_ff[ctrl.bit_sel]) begin
               row_in = row_ff | ctrl.pivot_row;
            end
         end
         default: row_in = row_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   assign row = row_ff;

endmodule

// ===== hw/rtl/tce_merge.sv =====
`timescale 1ns / 1ps
module tce_merge import tce_pkg::*; #(
   parameter int ROWS = 32,
   localparam int IW  = $clog2(ROWS)
) (
   input  logic [ROW_W-1:0] rows [ROWS],
   input  logic [IW-1:0]    sel,
   input  logic [ROW_W-1:0] col_mask,
   output logic [ROW_W-1:0] row_out
);

   // Pick the selected lane and drop columns of nodes not in use.
   always_comb begin
      row_out = '0;
      for (int i = 0; i < ROWS; i++) begin
         if (sel == IW'(i)) begin
            row_out = rows[i] & col_mask;
         end
      end
   end

endmodule

// ===== hw/rtl/transitive_closure_engine.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Transaction
// req_ch   in         adjacency_row[31:0], last_row
// rsp_ch   out        closed_row[31:0], row_number[4:0], last_out
// csr_*    in         node_count[5:0], written when csr_we is high
//
// Rows load one per cycle. After the last row, a prep step masks the rows, then the close
// phase runs one pivot per step across all lanes, then n closed rows leave one per cycle
// while rsp_ch.ready allows. For a run of n nodes, req_ch.ready stays low from the last row
// until the final closed row is issued; the pivot loop over the shared pivot-row
// select sets the closure time.
// Reset is synchronous and active high; row storage is not cleared.
// A stalled result holds the emit counter; new rows are taken once the final row is issued.
`include "transitive_closure_engine_macros.svh"
module transitive_closure_engine import tce_pkg::*; #(
   parameter int MAX_NODES = 32
) (
   input  logic        clock,
   input  logic        reset,
   tce_req_if.sink     req_ch,
   tce_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [5:0]  csr_wdata
);

   localparam int ROWS = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
   localparam int IW   = $clog2(ROWS);
   localparam int NW   = $clog2(ROWS + 1);

   phase_type        phase_ff, phase_in;
   logic [5:0]       node_count_ff;
   logic [NW-1:0]    load_count_ff, load_count_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [BIT_W-1:0] rsp_num_ff, rsp_num_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [NW-1:0]    n_act;
   logic [ROW_W:0]   mask_wide;
   logic [ROW_W-1:0] col_mask;
   logic             req_fire;
   logic             idx_last;
   logic             issue;
   lane_ctrl_type    ctrl;
   logic [ROW_W-1:0] lane_row [ROWS];
   logic [ROW_W-1:0] sel_row;

   // Node count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= 6'd32;
      end else if (csr_we) begin
         node_count_ff <= csr_wdata;
      end
   end

   // Active node count: zero counts as one, large values saturate.
   always_comb begin
      if (node_count_ff == 6'd0) begin
         n_act = NW'(1);
      end else if (node_count_ff > 6'(ROWS)) begin
         n_act = NW'(ROWS);
      end else begin
         n_act = NW'(node_count_ff);
      end
   end

   assign mask_wide = ((ROW_W + 1)'(1) << n_act) - (ROW_W + 1)'(1);
   assign col_mask  = mask_wide[ROW_W-1:0];
   assign req_fire  = req_ch.valid && req_ch.ready;
   assign idx_last  = (NW'(idx_ff) + NW'(1)) == n_act;
   assign issue     = (phase_ff == PH_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_LOAD:  if (req_fire && req_ch.last_row) phase_in = PH_PREP;
         PH_PREP:  phase_in = PH_CLOSE;
         PH_CLOSE: if (idx_last) phase_in = PH_EMIT;
         PH_EMIT:  if (issue && idx_last) phase_in = PH_LOAD;
         default:  phase_in = PH_LOAD;
      endcase
   end

   // Counters, lane control and result register.
   always_comb begin
      load_count_in  = load_count_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_row_in     = rsp_row_ff;
      rsp_num_in     = rsp_num_ff;
      rsp_last_in    = rsp_last_ff;
      ctrl.op         = LOP_HOLD;
      ctrl.load_sel   = BIT_W'(load_count_ff);
      ctrl.bit_sel    = BIT_W'(idx_ff);
      ctrl.fill_count = COUNT_W'(load_count_ff);
      ctrl.col_mask   = col_mask;
      ctrl.load_row   = req_ch.adjacency_row;
      ctrl.pivot_row  = sel_row;
      unique case (phase_ff)
         PH_LOAD: begin
            // Rows past the node count of this run are dropped.
            if (req_fire && (load_count_ff < n_act)) begin
               ctrl.op       = LOP_LOAD;
               load_count_in = load_count_ff + NW'(1);
            end
         end
         PH_PREP: begin
            ctrl.op       = LOP_PREP;
            load_count_in = '0;
            idx_in        = '0;
         end
         PH_CLOSE: begin
            ctrl.op = LOP_PIVOT;
            idx_in  = idx_last ? '0 : idx_ff + IW'(1);
         end
         PH_EMIT: begin
            if (issue) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = sel_row;
               rsp_num_in   = BIT_W'(idx_ff);
               rsp_last_in  = idx_last;
               idx_in       = idx_last ? '0 : idx_ff + IW'(1);
            end
         end
         default: ctrl.op = LOP_HOLD;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LOAD;
         load_count_ff <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         load_count_ff <= load_count_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      rsp_row_ff  <= rsp_row_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_last_ff <= rsp_last_in;
   end

   // One lane per matrix row.
   for (genvar g = 0; g < ROWS; g++) begin : g_lane
      tce_lane #(
         .LANE_IDX(g)
      ) u_lane (
         .clock(clock),
         .ctrl (ctrl),
         .row  (lane_row[g])
      );
   end

   // Shared row select for the pivot and for the result.
   tce_merge #(
      .ROWS(ROWS)
   ) u_merge (
      .rows    (lane_row),
      .sel     (idx_ff),
      .col_mask(col_mask),
      .row_out (sel_row)
   );

   assign req_ch.ready      = (phase_ff == PH_LOAD);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.closed_row = rsp_row_ff;
   assign rsp_ch.row_number = rsp_num_ff;
   assign rsp_ch.last_out   = rsp_last_ff;

   `TCE_ASSERT_NEXT(a_last_prep, req_fire && req_ch.last_row, phase_ff == PH_PREP, "no prep")
   `TCE_ASSERT_NEXT(a_prep, phase_ff == PH_PREP, phase_ff == PH_CLOSE && idx_ff == '0, "no close")
   `TCE_ASSERT(a_pivot_range, (phase_ff != PH_CLOSE) || (NW'(idx_ff) < n_act), "pivot out of range")
   `TCE_ASSERT_NEXT(a_run_end, issue && idx_last, rsp_ch.valid && rsp_ch.last_out, "no run end")
   `TCE_ASSERT_NEXT(a_run_load, issue && idx_last, phase_ff == PH_LOAD, "no reload")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import tce_pkg::*;

   localparam int NODES_MAX     = 32;
   localparam int ITEM_TARGET   = 500;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PLAN_LEN      = 23;

   // One closed row as it leaves the result channel.
   typedef struct packed {
      logic [ROW_W-1:0] closed_row;
      logic [BIT_W-1:0] row_number;
      logic             last_out;
   } closed_txn_type;

   // One step of the directed plan, with an optional hand-written result.
   typedef struct packed {
      logic               set_cfg;
      logic [COUNT_W-1:0] cfg_value;
      logic [ROW_W-1:0]   row;
      logic               last;
      logic               typed;
      logic [ROW_W-1:0]   typed_row;
   } plan_step_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we;
   logic [COUNT_W-1:0] csr_wdata;

   tce_req_if req_ch ();
   tce_rsp_if rsp_ch ();

   transitive_closure_engine #(.MAX_NODES(NODES_MAX)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Shadow copy of the matrix store and the node count register.
   logic [ROW_W-1:0]     adj_rows [NODES_MAX];
   logic [NODES_MAX-1:0] row_written = '0;
   logic [COUNT_W-1:0]   rows_loaded = '0;
   logic [COUNT_W-1:0]   node_count  = 6'd32;
   closed_txn_type       closure_due [$];
   int                   mismatches  = 0;
   int                   items_sent  = 0;
   int                   quiet_cycles = 0;
   int                   ready_hold  = 0;
   bit                   calm        = 1'b0;

   // Directed plan: extremes of the node count, extra rows, early last rows and
   // column bits beyond the active nodes.
   plan_step_type directed_plan [PLAN_LEN] = '{
      '{1'b0, 6'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
      '{1'b1, 6'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h1},
      '{1'b1, 6'd1,  32'h0000_0000, 1'b1, 1'b1, 32'h0},
      '{1'b0, 6'd0,  32'hFFFF_FFFE, 1'b1, 1'b1, 32'h0},
      '{1'b1, 6'd2,  32'h0000_0002, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h0000_0001, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'hFFFF_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h0000_FFFF, 1'b1, 1'b0, 32'h0},
      '{1'b1, 6'd3,  32'h0000_0002, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h0000_0004, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'hFFFF_FFF8, 1'b1, 1'b0, 32'h0},
      '{1'b1, 6'd63, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h0000_0001, 1'b1, 1'b0, 32'h0},
      '{1'b1, 6'd33, 32'h0000_0002, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h0000_0004, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h0000_0001, 1'b1, 1'b0, 32'h0},
      '{1'b1, 6'd5,  32'h5555_5555, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h0000_0010, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h0000_0008, 1'b1, 1'b0, 32'h0},
      '{1'b1, 6'd32, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0}
   };

   // A count of zero means one node; large counts saturate.
   function automatic int nodes_in_use();
      int n;
      n = node_count;
      if (n == 0) n = 1;
      if (n > 32) n = 32;
      if (n > NODES_MAX) n = NODES_MAX;
      return n;
   endfunction

   // Stores an accepted row and, on the last row, runs the closure and queues
   // the closed rows. Returns 0 for a row that the block drops, unless it is the last row.
   function automatic bit absorb_row(input logic [ROW_W-1:0] row, input logic last);
      int               n;
      logic [ROW_W-1:0] col_mask;
      logic [ROW_W-1:0] reach [NODES_MAX];
      bit               stored;
      closed_txn_type   txn;
      n = nodes_in_use();
      col_mask = (n == 32) ? '1 : ((32'h1 << n) - 32'h1);
      stored = 1'b0;
      if (rows_loaded < n) begin
         adj_rows[rows_loaded] = row;
         row_written[rows_loaded] = 1'b1;
         rows_loaded = rows_loaded + 1'b1;
         stored = 1'b1;
      end
      if (last) begin
         // Rows never written in this matrix read as empty.
         for (int i = 0; i < n; i++)
            reach[i] = row_written[i] ? (adj_rows[i] & col_mask) : '0;
         for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
               if (reach[i][k]) reach[i] = reach[i] | reach[k];
         for (int i = 0; i < n; i++) begin
            adj_rows[i] = reach[i];
            txn.closed_row = reach[i];
            txn.row_number = i[BIT_W-1:0];
            txn.last_out   = (i == n - 1);
            closure_due = {closure_due, txn};
         end
         rows_loaded = '0;
         row_written = '0;
      end
      return stored || last;
   endfunction

   // Random rows lean sparse so that reachability builds up over several pivots.
   function automatic logic [ROW_W-1:0] make_row(input int n);
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom & $urandom;
         2: return (32'h1 << $urandom_range(0, 31)) | (32'h1 << $urandom_range(0, n - 1));
         default: return ($urandom & $urandom & $urandom) | (32'h1 << $urandom_range(0, n - 1));
      endcase
   endfunction

   // Most matrices are small; a few are full size or use out-of-range counts.
   function automatic logic [COUNT_W-1:0] pick_node_count();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return COUNT_W'($urandom_range(33, 63));
         2, 3: return 6'd32;
         4, 5, 6: return COUNT_W'($urandom_range(9, 31));
         default: return COUNT_W'($urandom_range(1, 8));
      endcase
   endfunction

   // Sends one row transaction, with an occasional idle burst in front of it.
   task automatic send_row(input logic [ROW_W-1:0] row, input logic last, input bit gappy);
      int gap;
      gap = (gappy && !calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.adjacency_row <= row;
      req_ch.last_row      <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (absorb_row(row, last)) items_sent++;
   endtask

   // Waits until every closed row has come back and the block has gone quiet.
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      while (closure_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [COUNT_W-1:0] value);
      settle_block();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      node_count = value;
   endtask

   // Stimulus: reset, directed plan, then random matrices.
   initial begin
      int             n;
      int             count;
      bit             gappy;
      closed_txn_type fixed;
      req_ch.valid         <= 1'b0;
      req_ch.adjacency_row <= '0;
      req_ch.last_row      <= 1'b0;
      csr_we               <= 1'b0;
      csr_wdata            <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[s]) begin
         if (directed_plan[s].set_cfg) write_node_count(directed_plan[s].cfg_value);
         send_row(directed_plan[s].row, directed_plan[s].last, 1'b1);
         if (directed_plan[s].typed) begin
            // The closed rows of this matrix are the newest entries of the queue.
            repeat (nodes_in_use()) void'(closure_due.pop_back());
            fixed.closed_row = directed_plan[s].typed_row;
            fixed.row_number = '0;
            fixed.last_out   = 1'b1;
            closure_due = {closure_due, fixed};
         end
      end

      // Mostly complete matrices; some end early and some carry extra rows.
      while (items_sent < ITEM_TARGET) begin
         calm = (items_sent >= ITEM_TARGET * 4 / 5);
         if ($urandom_range(0, 2) == 0) write_node_count(pick_node_count());
         n = nodes_in_use();
         gappy = ($urandom_range(0, 2) != 0);
         case ($urandom_range(0, 7))
            0: count = $urandom_range(1, n);
            1: count = n + $urandom_range(1, 3);
            default: count = n;
         endcase
         for (int i = 0; i < count; i++) send_row(make_row(n), i == count - 1, gappy);
      end

      settle_block();
      if (mismatches == 0)
         $display("PASS transitive_closure_engine");
      else
         $display("FAIL transitive_closure_engine");
      $finish;
   end

   // Result side back-pressure: ready stretches broken by random stalls.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_ch.ready <= 1'b1;
         ready_hold   <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ch.ready) begin
         if ($urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            ready_hold   <= $urandom_range(0, 6);
         end else begin
            ready_hold <= $urandom_range(0, 20);
         end
      end else begin
         rsp_ch.ready <= 1'b1;
         ready_hold   <= $urandom_range(0, 20);
      end
   end

   // Each result transaction is checked against the oldest queued closed row.
   always @(posedge clock) begin : check_results
      closed_txn_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (closure_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result row=%h number=%0d last=%b", $realtime,
                        rsp_ch.closed_row, rsp_ch.row_number, rsp_ch.last_out);
         end else begin
            want = closure_due.pop_front();
            if (rsp_ch.closed_row !== want.closed_row || rsp_ch.row_number !== want.row_number
                || rsp_ch.last_out !== want.last_out) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: exp row=%h number=%0d last=%b, got row=%h number=%0d last=%b",
                           $realtime, want.closed_row, want.row_number, want.last_out,
                           rsp_ch.closed_row, rsp_ch.row_number, rsp_ch.last_out);
            end
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL transitive_closure_engine");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
